>>> hw/rtl/tdsm_pkg.sv
// Shared types and constants of the table-driven state machine engine.
package tdsm_pkg;

    localparam int STATE_W = 4;
    localparam int EVENT_W = 8;
    localparam int INDEX_W = 6;
    localparam int OP_W = 2;
    localparam int IN_USE_W = 7;
    localparam int MASK_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_SEND = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    localparam logic REG_IN_USE = 1'b0;
    localparam logic REG_MASK = 1'b1;

    typedef struct packed {
        logic [STATE_W-1:0] source;
        logic [EVENT_W-1:0] trigger;
        logic [STATE_W-1:0] target;
    } entry_t;

    typedef struct packed {
        logic [IN_USE_W-1:0] in_use;
        logic [MASK_W-1:0] action_mask;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic found;
        logic action;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } ctrl_state_t;

endpackage

>>> hw/rtl/tdsm_regs.sv
// APB configuration registers of the table-driven state machine engine.
module tdsm_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tdsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tdsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tdsm_pkg::cfg_t                    cfg
);
    import tdsm_pkg::*;

    logic [IN_USE_W-1:0] in_use_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            mask_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_IN_USE)
            begin
                in_use_reg <= pwdata[IN_USE_W-1:0];
            end
            else
            begin
                mask_reg <= pwdata[MASK_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MASK)
        begin
            prdata = {{(APB_DATA_W-MASK_W){1'b0}}, mask_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-IN_USE_W){1'b0}}, in_use_reg};
        end
    end

    assign cfg.in_use = in_use_reg;
    assign cfg.action_mask = mask_reg;

endmodule

>>> hw/rtl/tdsm_table_ram.sv
// Transition table memory with one write port and one registered read port.
module tdsm_table_ram #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  tdsm_pkg::entry_t      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output tdsm_pkg::entry_t      rdata
);
    import tdsm_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/tdsm_ctrl.sv
// Sequencer that handles items, scans the table and holds the result register.
module tdsm_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdsm_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tdsm_pkg::OP_W-1:0]     operation,
    input  logic [tdsm_pkg::EVENT_W-1:0]  event_code,
    input  logic [tdsm_pkg::INDEX_W-1:0]  entry_index,
    input  logic [tdsm_pkg::STATE_W-1:0]  entry_source,
    input  logic [tdsm_pkg::EVENT_W-1:0]  entry_event,
    input  logic [tdsm_pkg::STATE_W-1:0]  entry_target,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_waddr,
    output tdsm_pkg::entry_t              mem_wdata,
    output logic                          mem_re,
    output logic [ADDR_W-1:0]             mem_raddr,
    input  tdsm_pkg::entry_t              mem_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tdsm_pkg::result_t             out_res
);
    import tdsm_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [STATE_W-1:0]  present_reg, present_next;
    logic [EVENT_W-1:0]  event_reg, event_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;

    logic                accept;
    logic [CNT_W-1:0]    limit;
    logic [CNT_W-1:0]    idx_inc;
    logic [31:0]         widx;
    logic [31:0]         ridx;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign idx_inc = idx_reg + CNT_W'(1);
    assign widx = 32'(entry_index);
    assign ridx = 32'(idx_inc);

    always_comb
    begin
        if (32'(cfg.in_use) > 32'(TABLE_DEPTH))
        begin
            limit = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            limit = CNT_W'(cfg.in_use);
        end
    end

    assign mem_waddr = widx[ADDR_W-1:0];
    assign mem_wdata.source = entry_source;
    assign mem_wdata.trigger = entry_event;
    assign mem_wdata.target = entry_target;

    always_comb
    begin
        state_next = state_reg;
        present_next = present_reg;
        event_next = event_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next = out_res_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_raddr = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.state = present_reg;
                    res_next.found = 1'b0;
                    res_next.action = 1'b0;
                    state_next = ST_HOLD;
                    case (operation)
                        OP_SEND:
                        begin
                            res_next.action = cfg.action_mask[present_reg];
                            if (limit != '0)
                            begin
                                mem_re = 1'b1;
                                idx_next = '0;
                                cnt_next = limit;
                                event_next = event_code;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_WRITE:
                        begin
                            mem_we = (widx < 32'(TABLE_DEPTH));
                        end
                        OP_START:
                        begin
                            res_next.action = cfg.action_mask[present_reg];
                        end
                        default:
                        begin
                            res_next.action = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (mem_rdata.source == present_reg && mem_rdata.trigger == event_reg)
                begin
                    present_next = mem_rdata.target;
                    res_next.state = mem_rdata.target;
                    res_next.found = 1'b1;
                    res_next.action = cfg.action_mask[mem_rdata.target];
                    state_next = ST_HOLD;
                end
                else if (idx_inc == cnt_reg)
                begin
                    res_next.state = present_reg;
                    res_next.found = 1'b0;
                    res_next.action = cfg.action_mask[present_reg];
                    state_next = ST_HOLD;
                end
                else
                begin
                    idx_next = idx_inc;
                    mem_re = 1'b1;
                    mem_raddr = ridx[ADDR_W-1:0];
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_res_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            present_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            present_reg <= present_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
        res_reg <= res_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;

endmodule

>>> hw/rtl/table_driven_state_machine.sv
// Top level of the table-driven state machine engine.
// A send event reads table entries, one per cycle, up to the saturated in-use count.
// Write, start and unused-code items read no table entries; one item is handled at a time.
// Reset clears the present state, the registers and all handshakes; the table is not cleared.
module table_driven_state_machine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tdsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tdsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tdsm_pkg::OP_W-1:0]         operation,
    input  logic [tdsm_pkg::EVENT_W-1:0]      event_code,
    input  logic [tdsm_pkg::INDEX_W-1:0]      entry_index,
    input  logic [tdsm_pkg::STATE_W-1:0]      entry_source,
    input  logic [tdsm_pkg::EVENT_W-1:0]      entry_event,
    input  logic [tdsm_pkg::STATE_W-1:0]      entry_target,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdsm_pkg::STATE_W-1:0]      current_state_out,
    output logic                              transition_found,
    output logic                              run_action
);
    import tdsm_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    cfg_t               cfg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    entry_t             mem_rdata;
    result_t            out_res;

    tdsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdsm_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tdsm_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .event_code   (event_code),
        .entry_index  (entry_index),
        .entry_source (entry_source),
        .entry_event  (entry_event),
        .entry_target (entry_target),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (out_res)
    );

    assign current_state_out = out_res.state;
    assign transition_found = out_res.found;
    assign run_action = out_res.action;

endmodule

>>> hw/rtl/tdsm_checker.sv
// Port-level assertions for the table-driven state machine engine and their bind.
module tdsm_assertions (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [tdsm_pkg::OP_W-1:0]         operation,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [tdsm_pkg::STATE_W-1:0]      current_state_out,
    input logic                              transition_found,
    input logic                              run_action
);
    import tdsm_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // The engine handles one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input taken while an item is in progress");

    // Items other than send event never report a transition.
    a_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && operation != OP_SEND ##1 (!out_valid || !out_stall)
        |=> out_valid && !transition_found)
        else $error("non-event item result missing or reports a transition");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(current_state_out)
        && $stable(transition_found) && $stable(run_action))
        else $error("stalled result changed");

endmodule

bind table_driven_state_machine tdsm_assertions u_checker (.*);

>>> verif/tdsm_checker.sv
// Checker for the table-driven state machine: predicts every result and compares it.
`timescale 1ns / 100ps

module tdsm_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tdsm_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [tdsm_pkg::OP_W-1:0]       operation,
    input  logic [tdsm_pkg::EVENT_W-1:0]    event_code,
    input  logic [tdsm_pkg::INDEX_W-1:0]    entry_index,
    input  logic [tdsm_pkg::STATE_W-1:0]    entry_source,
    input  logic [tdsm_pkg::EVENT_W-1:0]    entry_event,
    input  logic [tdsm_pkg::STATE_W-1:0]    entry_target,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tdsm_pkg::STATE_W-1:0]    current_state_out,
    input  logic                            transition_found,
    input  logic                            run_action,
    output int                              mismatches,
    output int                              awaiting
);
    import tdsm_pkg::*;

    entry_t             transitions [TABLE_DEPTH];
    logic [STATE_W-1:0] machine_state;
    logic [IN_USE_W-1:0] in_use_count;
    logic [MASK_W-1:0]  action_bits;
    result_t            expected_results [$];
    int                 fault_count = 0;
    int                 open_count = 0;

    assign mismatches = fault_count;
    assign awaiting = open_count;

    function automatic result_t machine_response(
        input logic [OP_W-1:0]    op,
        input logic [EVENT_W-1:0] ev,
        input logic [INDEX_W-1:0] slot,
        input logic [STATE_W-1:0] source,
        input logic [EVENT_W-1:0] trigger,
        input logic [STATE_W-1:0] target
    );
        result_t reply;
        int      searched;
        logic    hit;
        reply = '0;
        hit = 1'b0;
        case (op)
            OP_SEND:
            begin
                searched = (in_use_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(in_use_count);
                for (int i = 0; i < searched && !hit; i++)
                begin
                    if (transitions[i].source == machine_state && transitions[i].trigger == ev)
                    begin
                        machine_state = transitions[i].target;
                        hit = 1'b1;
                    end
                end
                reply.found = hit;
                reply.action = action_bits[machine_state];
            end
            OP_WRITE:
            begin
                if (slot < TABLE_DEPTH)
                begin
                    transitions[slot] = '{source: source, trigger: trigger, target: target};
                end
            end
            OP_START:
            begin
                reply.action = action_bits[machine_state];
            end
            default:
            begin
            end
        endcase
        reply.state = machine_state;
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            machine_state = '0;
            in_use_count = '0;
            action_bits = '0;
            expected_results.delete();
            open_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MASK)
                begin
                    action_bits = pwdata[MASK_W-1:0];
                end
                else
                begin
                    in_use_count = pwdata[IN_USE_W-1:0];
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: %s %0d %0b %0b",
                             $time, "state, found, action", current_state_out,
                             transition_found, run_action);
                    fault_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (current_state_out !== want.state)
                    begin
                        $display("%0t: current_state_out expected %0d, got %0d",
                                 $time, want.state, current_state_out);
                        fault_count++;
                    end
                    if (transition_found !== want.found)
                    begin
                        $display("%0t: transition_found expected %0b, got %0b",
                                 $time, want.found, transition_found);
                        fault_count++;
                    end
                    if (run_action !== want.action)
                    begin
                        $display("%0t: run_action expected %0b, got %0b",
                                 $time, want.action, run_action);
                        fault_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(machine_response(operation, event_code,
                                                            entry_index, entry_source,
                                                            entry_event, entry_target));
            end
            open_count = expected_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Testbench top: drives stimulus into the state machine engine and reports the verdict.
`timescale 1ns / 100ps

module testbench;
    import tdsm_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int ALPHABET_SIZE = 8;
    localparam int ALPHABET_W = $clog2(ALPHABET_SIZE);
    localparam int DRAIN_GAP = 80;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_IN_USE = {REG_IN_USE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MASK = {REG_MASK, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = '0;
    logic [EVENT_W-1:0]    event_code = '0;
    logic [INDEX_W-1:0]    entry_index = '0;
    logic [STATE_W-1:0]    entry_source = '0;
    logic [EVENT_W-1:0]    entry_event = '0;
    logic [STATE_W-1:0]    entry_target = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATE_W-1:0]    current_state_out;
    logic                  transition_found;
    logic                  run_action;
    int                    mismatches;
    int                    awaiting;

    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_requests = 0;
    logic [EVENT_W-1:0]    alphabet [ALPHABET_SIZE];

    table_driven_state_machine #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

    tdsm_checker #(.TABLE_DEPTH(TABLE_DEPTH)) observer (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // The receiver stalls at random, and grants each requested long hold-off in turn.
    initial
    begin
        int holds_granted;
        holds_granted = 0;
        forever
        begin
            @(negedge clk);
            if (holds_granted < hold_requests)
            begin
                holds_granted++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic offer(input logic [OP_W-1:0] op, input logic [EVENT_W-1:0] ev,
                         input logic [INDEX_W-1:0] slot, input logic [STATE_W-1:0] source,
                         input logic [EVENT_W-1:0] trigger, input logic [STATE_W-1:0] target);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        event_code <= ev;
        entry_index <= slot;
        entry_source <= source;
        entry_event <= trigger;
        entry_target <= target;
        do @(posedge clk); while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    function automatic logic [EVENT_W-1:0] pick_event();
        if ($urandom_range(99) < 85)
        begin
            return alphabet[ALPHABET_W'($urandom_range(ALPHABET_SIZE-1))];
        end
        return EVENT_W'($urandom);
    endfunction

    task automatic random_item();
        int                 pick;
        logic [EVENT_W-1:0] ev;
        pick = $urandom_range(99);
        ev = pick_event();
        if (pick < 70)
        begin
            offer(OP_SEND, ev, INDEX_W'($urandom), STATE_W'($urandom),
                  EVENT_W'($urandom), STATE_W'($urandom));
        end
        else if (pick < 84)
        begin
            offer(OP_WRITE, EVENT_W'($urandom), INDEX_W'($urandom), STATE_W'($urandom),
                  ev, STATE_W'($urandom));
        end
        else if (pick < 96)
        begin
            offer(OP_START, EVENT_W'($urandom), INDEX_W'($urandom), STATE_W'($urandom),
                  EVENT_W'($urandom), STATE_W'($urandom));
        end
        else
        begin
            offer(OP_RESERVED, EVENT_W'($urandom), INDEX_W'($urandom), STATE_W'($urandom),
                  EVENT_W'($urandom), STATE_W'($urandom));
        end
    endtask

    initial
    begin
        int in_use_plan [PHASES];
        in_use_plan = '{64, 127, 1, 32, 0, 100, 64, 17};
        for (int k = 0; k < ALPHABET_SIZE; k++)
        begin
            alphabet[k] = EVENT_W'($urandom);
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With nothing searched, send events can never match and the table is never read.
        write_register(ADDR_IN_USE, 0);
        write_register(ADDR_MASK, 32'h0000_FFFF);
        offer(OP_START, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_SEND, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_SEND, 8'hFF, 6'd63, 4'hF, 8'hFF, 4'hF);
        offer(OP_RESERVED, 8'hFF, 6'd63, 4'hF, 8'hFF, 4'hF);
        offer(OP_WRITE, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_WRITE, 8'hFF, 6'd63, 4'hF, 8'hFF, 4'hF);

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            offer(OP_WRITE, EVENT_W'($urandom), INDEX_W'(i), STATE_W'($urandom),
                  pick_event(), STATE_W'($urandom));
        end
        settle();
        write_register(ADDR_IN_USE, 3);
        write_register(ADDR_MASK, 32'h0000_8000);

        // The second and third entries share source and event, so the second must win.
        offer(OP_WRITE, 8'h00, 6'd0, 4'h0, 8'hA5, 4'hF);
        offer(OP_WRITE, 8'h00, 6'd1, 4'hF, 8'h3C, 4'h7);
        offer(OP_WRITE, 8'h00, 6'd2, 4'hF, 8'h3C, 4'h9);
        offer(OP_SEND, 8'hA5, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_START, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_SEND, 8'h3C, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_SEND, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        offer(OP_START, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);
        settle();
        write_register(ADDR_MASK, 32'h0000_0000);
        offer(OP_START, 8'h00, 6'd0, 4'h0, 8'h00, 4'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_register(ADDR_IN_USE, in_use_plan[p]);
            if (p == 1)
            begin
                write_register(ADDR_MASK, 32'h0000_0000);
            end
            else if (p == 3)
            begin
                write_register(ADDR_MASK, 32'h0000_FFFF);
            end
            else
            begin
                write_register(ADDR_MASK, $urandom_range(16'hFFFF));
            end
            idle_pct = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 33 : 0;
            stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 33 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((p == 2 || p == 6) && n == 40)
                begin
                    hold_requests++;
                end
                if ((p == 3 || p == 5) && n == 50)
                begin
                    settle();
                end
                random_item();
            end
        end

        settle();
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> table_driven_state_machine.f
hw/rtl/tdsm_pkg.sv
hw/rtl/tdsm_regs.sv
hw/rtl/tdsm_table_ram.sv
hw/rtl/tdsm_ctrl.sv
hw/rtl/table_driven_state_machine.sv
hw/rtl/tdsm_checker.sv
verif/tdsm_checker.sv
verif/testbench.sv
